// File: design/ofp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ofp_pkg
// shared types and constants for the off-axis frustum projection block
// ----------------------------------------------------------------------------
package ofp_pkg;

  localparam int NumLanes = 6;
  localparam int QuoBits  = 32;

  localparam int LaneXScale     = 0;
  localparam int LaneYScale     = 1;
  localparam int LaneXShift     = 2;
  localparam int LaneYShift     = 3;
  localparam int LaneDepthScale = 4;
  localparam int LaneDepthOff   = 5;

  localparam logic signed [31:0] EzMinRaw      = 32'sd65;
  localparam logic [30:0]        EzFallbackRaw = 31'd42598;

  typedef enum logic [1:0] {
    REG_SCREEN_WIDTH  = 2'd0,
    REG_SCREEN_HEIGHT = 2'd1,
    REG_NEAR_PLANE    = 2'd2,
    REG_FAR_PLANE     = 2'd3
  } reg_idx_t;

  typedef logic [63:0]                 acc_t;
  typedef acc_t [NumLanes-1:0]         acc_arr_t;
  typedef logic [NumLanes-1:0][30:0]   den_arr_t;

  typedef struct packed {
    logic                valid;
    logic [NumLanes-1:0] neg;
    logic [NumLanes-1:0] ovf;
    logic [NumLanes-1:0] zero;
  } side_t;

endpackage

// File: design/ofp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ofp_front
// two prep stages: eye magnitudes, f*n, f+n, then dividends and overflow flags
// ----------------------------------------------------------------------------
module ofp_front import ofp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  logic               in_take,
  input  logic signed [31:0] eye_x,
  input  logic signed [31:0] eye_y,
  input  logic signed [31:0] eye_z,
  input  logic [30:0]        near_plane,
  input  logic [30:0]        far_plane,
  input  den_arr_t           den,
  input  logic               w_zero,
  input  logic               h_zero,
  output acc_arr_t           acc,
  output side_t              side
);

  logic        v1;
  logic [30:0] ez;
  logic [31:0] mx;
  logic [31:0] my;
  logic        nx;
  logic        ny;
  logic [61:0] prod;
  logic [31:0] fsum;
  acc_arr_t    num;
  side_t       side_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= in_take;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ez   <= (eye_z <= EzMinRaw) ? EzFallbackRaw : eye_z[30:0];
      mx   <= eye_x[31] ? (32'd0 - eye_x) : eye_x;
      my   <= eye_y[31] ? (32'd0 - eye_y) : eye_y;
      nx   <= (eye_x > 32'sd0);
      ny   <= (eye_y > 32'sd0);
      prod <= 62'(near_plane) * 62'(far_plane);
      fsum <= 32'(near_plane) + 32'(far_plane);
    end
  end

  always_comb begin
    num[LaneXScale]     = {16'd0, ez, 17'd0};
    num[LaneYScale]     = {16'd0, ez, 17'd0};
    num[LaneXShift]     = {15'd0, mx, 17'd0};
    num[LaneYShift]     = {15'd0, my, 17'd0};
    num[LaneDepthScale] = {16'd0, fsum, 16'd0};
    num[LaneDepthOff]   = {1'b0, prod, 1'b0};
    side_next.valid = v1;
    side_next.neg = '0;
    side_next.neg[LaneXShift]     = nx;
    side_next.neg[LaneYShift]     = ny;
    side_next.neg[LaneDepthScale] = far_plane > near_plane;
    side_next.neg[LaneDepthOff]   = far_plane > near_plane;
    side_next.zero[LaneXScale]     = w_zero || (near_plane == 31'd0);
    side_next.zero[LaneXShift]     = w_zero || (near_plane == 31'd0);
    side_next.zero[LaneYScale]     = h_zero || (near_plane == 31'd0);
    side_next.zero[LaneYShift]     = h_zero || (near_plane == 31'd0);
    side_next.zero[LaneDepthScale] = far_plane == near_plane;
    side_next.zero[LaneDepthOff]   = far_plane == near_plane;
    for (int i = 0; i < NumLanes; i++) begin
      side_next.ovf[i] = num[i][63:32] >= {1'b0, den[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side <= '0;
    end else if (adv) begin
      side <= side_next;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < NumLanes; i++) begin
        acc[i] <= side_next.ovf[i] ? 64'd0 : num[i];
      end
    end
  end

endmodule

// File: design/ofp_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ofp_cell
// one restoring division step for every lane, one quotient bit per cell
// ----------------------------------------------------------------------------
module ofp_cell import ofp_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     adv,
  input  den_arr_t den,
  input  acc_arr_t acc_in,
  input  side_t    side_in,
  output acc_arr_t acc_out,
  output side_t    side_out
);

  acc_arr_t    acc_next;
  logic [64:0] t;
  logic [32:0] hi;
  logic        b;

  always_comb begin
    for (int i = 0; i < NumLanes; i++) begin
      t  = {acc_in[i], 1'b0};
      b  = t[64:32] >= {2'b0, den[i]};
      hi = b ? (t[64:32] - {2'b0, den[i]}) : t[64:32];
      acc_next[i] = {hi[31:0], t[31:1], b};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side_out <= '0;
    end else if (adv) begin
      side_out <= side_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      acc_out <= acc_next;
    end
  end

endmodule

// File: design/off_axis_frustum_projection.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// off_axis_frustum_projection
// asymmetric frustum projection entries from one eye position per request
// ----------------------------------------------------------------------------
//  channel | signals                                   | direction
//  in      | in_valid/in_ready, eye_x eye_y eye_z      | request in
//  out     | out_valid/out_ready, six entries + fault  | request out
//  cfg     | cfg_valid/cfg_ready, cfg_index cfg_data   | register write
//
//  one request per cycle unless the output stalls; the pipeline is two prep
//  stages, a chain of 32 division cells (one quotient bit each, six lanes side
//  by side), and the rounding and saturation output register
//  reset restores the four registers and empties the chain
//  a stalled output freezes the whole chain; cfg_ready is always high
// ----------------------------------------------------------------------------
module off_axis_frustum_projection import ofp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] eye_x,
  input  logic signed [31:0] eye_y,
  input  logic signed [31:0] eye_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] x_scale,
  output logic signed [31:0] y_scale,
  output logic signed [31:0] x_shift,
  output logic signed [31:0] y_shift,
  output logic signed [31:0] depth_scale,
  output logic signed [31:0] depth_offset,
  output logic               fault,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  logic [30:0] screen_width;
  logic [30:0] screen_height;
  logic [30:0] near_plane;
  logic [30:0] far_plane;
  logic [30:0] dspan;
  den_arr_t    den;
  logic        adv;

  acc_arr_t acc [QuoBits+1];
  side_t    side [QuoBits+1];

  logic [NumLanes-1:0][31:0] res;
  logic                      fault_next;
  logic [32:0]               mag;
  logic                      rnd;

  assign cfg_ready = 1'b1;
  assign adv       = !out_valid || out_ready;
  assign in_ready  = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= 31'd65536;
      screen_height <= 31'd65536;
      near_plane    <= 31'd6554;
      far_plane     <= 31'd6553600;
    end else if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_SCREEN_WIDTH:  screen_width  <= cfg_data[30:0];
        REG_SCREEN_HEIGHT: screen_height <= cfg_data[30:0];
        REG_NEAR_PLANE:    near_plane    <= cfg_data[30:0];
        REG_FAR_PLANE:     far_plane     <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    dspan = (far_plane > near_plane) ? (far_plane - near_plane)
                                     : (near_plane - far_plane);
    den[LaneXScale]     = screen_width;
    den[LaneXShift]     = screen_width;
    den[LaneYScale]     = screen_height;
    den[LaneYShift]     = screen_height;
    den[LaneDepthScale] = dspan;
    den[LaneDepthOff]   = dspan;
  end

  ofp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .in_take    (in_valid),
    .eye_x      (eye_x),
    .eye_y      (eye_y),
    .eye_z      (eye_z),
    .near_plane (near_plane),
    .far_plane  (far_plane),
    .den        (den),
    .w_zero     (screen_width == 31'd0),
    .h_zero     (screen_height == 31'd0),
    .acc        (acc[0]),
    .side       (side[0])
  );

  for (genvar g = 0; g < QuoBits; g++) begin : g_cell
    ofp_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .adv      (adv),
      .den      (den),
      .acc_in   (acc[g]),
      .side_in  (side[g]),
      .acc_out  (acc[g+1]),
      .side_out (side[g+1])
    );
  end

  always_comb begin
    fault_next = 1'b0;
    for (int i = 0; i < NumLanes; i++) begin
      rnd = {acc[QuoBits][i][63:32], 1'b0} >= {2'b0, den[i]};
      mag = {1'b0, acc[QuoBits][i][31:0]} + {32'd0, rnd};
      if (side[QuoBits].ovf[i]) begin
        mag = 33'h1_0000_0000;
      end
      if (side[QuoBits].zero[i]) begin
        fault_next = 1'b1;
        res[i] = 32'd0;
      end else if (side[QuoBits].neg[i]) begin
        if (mag > 33'h0_8000_0000) begin
          fault_next = 1'b1;
          mag = 33'h0_8000_0000;
        end
        res[i] = 32'd0 - mag[31:0];
      end else begin
        if (mag > 33'h0_7FFF_FFFF) begin
          fault_next = 1'b1;
          mag = 33'h0_7FFF_FFFF;
        end
        res[i] = mag[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= side[QuoBits].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x_scale      <= res[LaneXScale];
      y_scale      <= res[LaneYScale];
      x_shift      <= res[LaneXShift];
      y_shift      <= res[LaneYShift];
      depth_scale  <= res[LaneDepthScale];
      depth_offset <= res[LaneDepthOff];
      fault        <= fault_next;
    end
  end

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// off-axis frustum projection: directed corners of eye position and planes,
// then random eye positions under several screen and clip settings, each
// result checked field by field against a local projection predictor
// ----------------------------------------------------------------------------
module tb import ofp_pkg::*; ;

  typedef struct packed {
    logic signed [31:0] xs;
    logic signed [31:0] ys;
    logic signed [31:0] xh;
    logic signed [31:0] yh;
    logic signed [31:0] dsc;
    logic signed [31:0] dof;
    logic               flt;
  } proj_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] eye_x = '0, eye_y = '0, eye_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] x_scale, y_scale, x_shift, y_shift, depth_scale, depth_offset;
  logic fault;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  logic [30:0] width_q, height_q, near_q, far_q;
  proj_t expected_proj[$];
  int errors = 0;
  int hold_cycles = 0;
  bit idle_in = 1'b1;
  bit idle_out = 1'b1;

  off_axis_frustum_projection u_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #200ms;
    $display("tb failed");
    $finish;
  end

  function automatic logic [63:0] round_div(logic [63:0] num, logic [63:0] den);
    logic [63:0] q, r;
    q = num / den;
    r = num % den;
    if (r >= den - r) q++;
    return q;
  endfunction

  function automatic logic [31:0] clamp(logic [63:0] mag, bit neg, ref bit flt);
    if (neg) begin
      if (mag > 64'h8000_0000) begin
        flt = 1'b1;
        mag = 64'h8000_0000;
      end
      return 32'(-mag);
    end
    if (mag > 64'h7fff_ffff) begin
      flt = 1'b1;
      mag = 64'h7fff_ffff;
    end
    return mag[31:0];
  endfunction

  function automatic void axis(logic [63:0] span, logic [63:0] ez, logic signed [31:0] e,
                               ref logic [31:0] scl, ref logic [31:0] shf, ref bit flt);
    logic [63:0] mag;
    if (span == 0 || near_q == 0) begin
      flt = 1'b1;
      scl = '0;
      shf = '0;
      return;
    end
    scl = clamp(round_div(2 * ez * 65536, span), 1'b0, flt);
    mag = (e < 0) ? 64'(-64'(e)) : 64'(e);
    shf = clamp(round_div(2 * mag * 65536, span), e > 0, flt);
  endfunction

  function automatic proj_t project(logic signed [31:0] ex, logic signed [31:0] ey,
                                    logic signed [31:0] ez_in);
    proj_t p;
    bit flt;
    logic [63:0] ez, f, n, d;
    logic [31:0] a, b;
    flt = 1'b0;
    ez = (ez_in <= EzMinRaw) ? 64'(EzFallbackRaw) : 64'(ez_in);
    axis(width_q, ez, ex, a, b, flt);
    p.xs = a;
    p.xh = b;
    axis(height_q, ez, ey, a, b, flt);
    p.ys = a;
    p.yh = b;
    f = far_q;
    n = near_q;
    if (f == n) begin
      flt = 1'b1;
      p.dsc = '0;
      p.dof = '0;
    end else begin
      d = (f > n) ? f - n : n - f;
      p.dsc = clamp(round_div((f + n) * 65536, d), f > n, flt);
      p.dof = clamp(round_div(2 * f * n, d), f > n, flt);
    end
    p.flt = flt;
    return p;
  endfunction

  task automatic send_eye(logic signed [31:0] ex, logic signed [31:0] ey,
                          logic signed [31:0] ez);
    if (idle_in) begin
      while ($urandom_range(99) < 25) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    eye_x <= ex;
    eye_y <= ey;
    eye_z <= ez;
    expected_proj.push_back(project(ex, ey, ez));
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_proj.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [30:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= {1'($urandom_range(1)), val};
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_SCREEN_WIDTH: width_q = val;
      REG_SCREEN_HEIGHT: height_q = val;
      REG_NEAR_PLANE: near_q = val;
      default: far_q = val;
    endcase
  endtask

  task automatic set_all(logic [30:0] w, logic [30:0] h, logic [30:0] n, logic [30:0] f);
    write_reg(REG_SCREEN_WIDTH, w);
    write_reg(REG_SCREEN_HEIGHT, h);
    write_reg(REG_NEAR_PLANE, n);
    write_reg(REG_FAR_PLANE, f);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] rand_field();
    case ($urandom_range(5))
      0: return $urandom_range(200) - 100;
      1: return {$urandom_range(1) ? 16'hffff : 16'h0000, 16'($urandom)};
      2: return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [30:0] rand_reg();
    case ($urandom_range(3))
      0: return 31'($urandom_range(8));
      1: return 31'($urandom_range(200000));
      2: return 31'(32'h7fff_ffff - $urandom_range(4));
      default: return 31'($urandom);
    endcase
  endfunction

  task automatic test_directed();
    logic signed [31:0] vals[8] = '{32'sh8000_0000, 32'sh7fff_ffff, 0, 1, -1, 65, 66, 32'sh10000};
    foreach (vals[i]) send_eye(vals[i], vals[7 - i], vals[i]);
    send_eye(32'sh20000, -32'sh8000, 32'sh9999);
    send_eye(0, 0, 64);
    drain();
  endtask

  task automatic test_config_extremes();
    set_all(0, 1, 6554, 6554);
    send_eye(32'sh10000, 32'sh10000, 32'sh10000);
    drain();
    set_all(1, 0, 0, 31'h7fff_ffff);
    send_eye(-32'sh10000, 5, 32'sh7fff_ffff);
    drain();
    set_all(31'h7fff_ffff, 31'h7fff_ffff, 31'h7fff_ffff, 1);
    send_eye(32'sh8000_0000, 32'sh7fff_ffff, 0);
    send_eye(3, -3, 100);
    drain();
  endtask

  task automatic test_random(int count);
    repeat (count) send_eye(rand_field(), rand_field(), rand_field());
  endtask

  task automatic test_backpressure();
    hold_cycles = 120;
    repeat (80) send_eye(rand_field(), rand_field(), rand_field());
    drain();
  endtask

  task automatic test_no_idle();
    idle_in = 1'b0;
    idle_out = 1'b0;
    test_random(200);
    drain();
    idle_in = 1'b1;
    idle_out = 1'b1;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !idle_out || ($urandom_range(99) >= 25);
    end
  end

  always @(posedge clk) begin
    proj_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_proj.size() == 0) begin
        $error("result with no request pending");
        errors++;
      end else begin
        e = expected_proj.pop_front();
        if (x_scale !== e.xs) begin
          $error("x_scale exp %h got %h", e.xs, x_scale);
          errors++;
        end
        if (y_scale !== e.ys) begin
          $error("y_scale exp %h got %h", e.ys, y_scale);
          errors++;
        end
        if (x_shift !== e.xh) begin
          $error("x_shift exp %h got %h", e.xh, x_shift);
          errors++;
        end
        if (y_shift !== e.yh) begin
          $error("y_shift exp %h got %h", e.yh, y_shift);
          errors++;
        end
        if (depth_scale !== e.dsc) begin
          $error("depth_scale exp %h got %h", e.dsc, depth_scale);
          errors++;
        end
        if (depth_offset !== e.dof) begin
          $error("depth_offset exp %h got %h", e.dof, depth_offset);
          errors++;
        end
        if (fault !== e.flt) begin
          $error("fault exp %b got %b", e.flt, fault);
          errors++;
        end
      end
    end
  end

  initial begin
    width_q = 31'd65536;
    height_q = 31'd65536;
    near_q = 31'd6554;
    far_q = 31'd6553600;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_config_extremes();
    set_all(31'd65536, 31'd65536, 31'd6554, 31'd6553600);
    test_random(300);
    drain();
    test_backpressure();
    test_no_idle();
    repeat (7) begin
      set_all(rand_reg(), rand_reg(), rand_reg(), rand_reg());
      test_random(150);
      drain();
    end
    if (errors == 0 && expected_proj.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

// File: files.f
design/ofp_pkg.sv
design/ofp_front.sv
design/ofp_cell.sv
design/off_axis_frustum_projection.sv
tb/sv/tb.sv
